// ===== rtl/u4ba_pkg.sv =====
// Shared constants, register codes and interpolation helpers for the 4x upsampler.
`timescale 1ns / 1ps
package u4ba_pkg;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_DEPTH  = 32;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CH_W       = $clog2(MAX_DEPTH);
	localparam int LINE_AW    = COL_W + CH_W;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_DEPTH  = 2'd2
	} reg_idx_t;

	function automatic logic [7:0] mix31(input logic [7:0] a, input logic [7:0] b);
		logic [9:0] t;
		t = {2'b00, a} + {1'b0, a, 1'b0} + {2'b00, b};
		return t[9:2];
	endfunction

	function automatic logic [7:0] mix11(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[8:1];
	endfunction
endpackage

// ===== rtl/upsample4x_bilinear_argmax_unit.sv =====
// Top level: streaming 4x bilinear upsampler with per-pixel class argmax.
`timescale 1ns / 1ps
// Score bytes enter one per cycle in raster order (row, column, channel) unless in_stall
// is high. Each byte is written to a line store and its neighbours are read in the same
// cycle; in the following cycle the sixteen bilinear maxima are updated. A completed pixel
// hands up to eight result items (two 4x4 blocks, one output row each) to an emitter that
// issues one item a cycle while the output does not stall. A byte that completes a pixel
// waits until every item of the previous pixel has been emitted, so with no output stalls
// the input takes one byte a cycle when depth is at least ten, or at least six away from
// the last column and row; output stalls slow it further. Writing any register restarts
// the frame.
module upsample4x_bilinear_argmax_unit import u4ba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  score,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] out_row,
	output logic [9:0]  out_col,
	output logic [4:0]  class0,
	output logic [4:0]  class1,
	output logic [4:0]  class2,
	output logic [4:0]  class3,
	output logic        last
);
	logic [8:0]  width_q;
	logic [10:0] height_q;
	logic [5:0]  depth_q;
	logic [8:0]  wc;
	logic [10:0] hc;
	logic [5:0]  dc;

	logic [CH_W-1:0]  k_q;
	logic [COL_W-1:0] c_q;
	logic [ROW_W-1:0] r_q;
	logic             last0, in_acc;

	logic [7:0] line_mem [1 << LINE_AW];
	logic [4:0] cw_mem [MAX_WIDTH];
	logic [7:0] lps_q [MAX_DEPTH];
	logic [7:0] tr_rd_q, bl_rd_q;
	logic [4:0] cw_tr_q, cw_bl_q;

	logic             valid_s1, last_s1, inner_s1, edge_s1;
	logic [7:0]       s_s1;
	logic [CH_W-1:0]  k_s1;
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] r_s1;

	logic [7:0] pm_q [16];
	logic [4:0] pw_q [16];
	logic [7:0] pmax_q;
	logic [4:0] pwin_q;
	logic [4:0] al_q;

	logic [7:0] tl, top [4], bot [4], v [16];
	logic [7:0] pm_n [16];
	logic [4:0] pw_n [16];
	logic [7:0] pmax_n;
	logic [4:0] pwin_n;
	logic       cw_we;

	logic             job_valid_q, job_inner_q, job_edge_q, job_fill_q;
	logic [2:0]       job_idx_q;
	logic [4:0]       job_fcls_q, job_w_q;
	logic [4:0]       job_cls_q [16];
	logic [COL_W-1:0] job_c_q;
	logic [ROW_W-1:0] job_r_q;
	logic             emit, e_inner, e_last;
	logic [1:0]       e_sub;

	assign wc = (width_q == 9'd0) ? 9'd1 : (width_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_q;
	assign hc = (height_q == 11'd0) ? 11'd1 :
		(height_q > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_q;
	assign dc = (depth_q == 6'd0) ? 6'd1 : (depth_q > 6'(MAX_DEPTH)) ? 6'(MAX_DEPTH) : depth_q;

	assign last0    = ({1'b0, k_q} == dc - 6'd1);
	assign in_stall = last0 && (job_valid_q || (valid_s1 && last_s1));
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 11'd256;
			depth_q  <= 6'd32;
			k_q      <= '0;
			c_q      <= '0;
			r_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[8:0];
				REG_HEIGHT: height_q <= cfg_data;
				REG_DEPTH:  depth_q  <= cfg_data[5:0];
				default: ;
			endcase
			if (cfg_index <= REG_DEPTH) begin
				k_q <= '0;
				c_q <= '0;
				r_q <= '0;
			end
		end else if (in_acc) begin
			if (!last0) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
				if ({1'b0, c_q} != wc - 9'd1) begin
					c_q <= c_q + 1'b1;
				end else begin
					c_q <= '0;
					r_q <= ({1'b0, r_q} != hc - 11'd1) ? r_q + 1'b1 : '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			line_mem[{c_q, k_q}] <= score;
			tr_rd_q <= line_mem[{c_q, k_q}];
			bl_rd_q <= line_mem[{c_q - 1'b1, k_q}];
			cw_tr_q <= (cw_we && c_s1 == c_q) ? pwin_n : cw_mem[c_q];
			cw_bl_q <= (cw_we && c_s1 == c_q - 1'b1) ? pwin_n : cw_mem[c_q - 1'b1];
		end
		if (cw_we)
			cw_mem[c_s1] <= pwin_n;
		if (valid_s1)
			lps_q[k_s1] <= tr_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_s1     <= score;
			k_s1     <= k_q;
			c_s1     <= c_q;
			r_s1     <= r_q;
			last_s1  <= last0;
			inner_s1 <= (r_q != '0) && (c_q != '0);
			edge_s1  <= ({1'b0, c_q} == wc - 9'd1) || ({1'b0, r_q} == hc - 11'd1);
		end
	end

	always_comb begin
		tl = lps_q[k_s1];
		top[0] = tl;
		top[1] = mix31(tl, tr_rd_q);
		top[2] = mix11(tl, tr_rd_q);
		top[3] = mix31(tr_rd_q, tl);
		bot[0] = bl_rd_q;
		bot[1] = mix31(bl_rd_q, s_s1);
		bot[2] = mix11(bl_rd_q, s_s1);
		bot[3] = mix31(s_s1, bl_rd_q);
		for (int i = 0; i < 4; i++) begin
			v[i]      = top[i];
			v[i + 4]  = mix31(top[i], bot[i]);
			v[i + 8]  = mix11(top[i], bot[i]);
			v[i + 12] = mix31(bot[i], top[i]);
		end
		for (int i = 0; i < 16; i++) begin
			pm_n[i] = (k_s1 == '0) ? 8'd0 : pm_q[i];
			pw_n[i] = (k_s1 == '0) ? 5'd0 : pw_q[i];
			if (inner_s1 && v[i] > pm_n[i]) begin
				pm_n[i] = v[i];
				pw_n[i] = 5'(k_s1);
			end
		end
		if (k_s1 == '0) begin
			pmax_n = s_s1;
			pwin_n = 5'd0;
		end else if (s_s1 > pmax_q) begin
			pmax_n = s_s1;
			pwin_n = 5'(k_s1);
		end else begin
			pmax_n = pmax_q;
			pwin_n = pwin_q;
		end
		cw_we = valid_s1 && last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				pm_q[i] <= '0;
				pw_q[i] <= '0;
			end
			pmax_q <= '0;
			pwin_q <= '0;
			al_q   <= '0;
		end else if (valid_s1) begin
			pm_q   <= pm_n;
			pw_q   <= pw_n;
			pmax_q <= pmax_n;
			pwin_q <= pwin_n;
			if (last_s1)
				al_q <= cw_tr_q;
		end
	end

	assign emit    = job_valid_q && (!out_valid || !out_stall);
	assign e_inner = job_inner_q && !job_idx_q[2];
	assign e_sub   = job_idx_q[1:0];
	assign e_last  = (e_sub == 2'd3) && (job_idx_q[2] || !job_edge_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			job_idx_q   <= '0;
		end else if (cw_we && (inner_s1 || edge_s1)) begin
			job_valid_q <= 1'b1;
			job_idx_q   <= inner_s1 ? 3'd0 : 3'd4;
		end else if (emit) begin
			job_idx_q <= job_idx_q + 1'b1;
			if (e_last)
				job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw_we) begin
			job_inner_q <= inner_s1;
			job_edge_q  <= edge_s1;
			job_fill_q  <= (al_q == cw_tr_q) && (cw_tr_q == cw_bl_q) && (cw_bl_q == pwin_n);
			job_fcls_q  <= al_q;
			job_w_q     <= pwin_n;
			job_cls_q   <= pw_n;
			job_c_q     <= c_s1;
			job_r_q     <= r_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			last <= e_last;
			if (e_inner) begin
				out_row <= {job_r_q - 1'b1, e_sub};
				out_col <= {job_c_q - 1'b1, 2'b00};
				if (job_fill_q) begin
					class0 <= job_fcls_q;
					class1 <= job_fcls_q;
					class2 <= job_fcls_q;
					class3 <= job_fcls_q;
				end else begin
					class0 <= job_cls_q[{e_sub, 2'd0}];
					class1 <= job_cls_q[{e_sub, 2'd1}];
					class2 <= job_cls_q[{e_sub, 2'd2}];
					class3 <= job_cls_q[{e_sub, 2'd3}];
				end
			end else begin
				out_row <= {job_r_q, e_sub};
				out_col <= {job_c_q, 2'b00};
				class0  <= job_w_q;
				class1  <= job_w_q;
				class2  <= job_w_q;
				class3  <= job_w_q;
			end
		end
	end
endmodule

// ===== rtl/u4ba_checker.sv =====
// Port-level checks for the upsampler, bound to the top level.
`timescale 1ns / 1ps
module u4ba_checker import u4ba_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] out_row,
	input logic [9:0]  out_col,
	input logic        last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col))
		else $error("stalled item changed");

	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_col[1:0] == 2'd0)
		else $error("column not block aligned");

	a_lastrow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_row[1:0] == 2'd3)
		else $error("final item not on last row of block");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last && out_row[1:0] != 2'd3
		|=> out_valid && out_row == $past(out_row) + 12'd1)
		else $error("block rows not consecutive");
endmodule

bind upsample4x_bilinear_argmax_unit u4ba_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.out_row(out_row), .out_col(out_col), .last(last)
);
